// File: hw/rtl/dpb_pkg.sv
package dpb_pkg;

    // field widths fixed by the point format
    localparam int DEPTH_W   = 16;
    localparam int FOCAL_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COLOUR_W  = 8;
    localparam int POS_W     = 32;

    // long division: quotient bits and how they are spread over stages
    localparam int QUO_W          = 32;
    localparam int DIV_STAGES     = 8;
    localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // register reset values
    localparam logic [CFG_W-1:0]    CENTER_COL_RST = 16'd5128;
    localparam logic [CFG_W-1:0]    CENTER_ROW_RST = 16'd3848;
    localparam logic [FOCAL_W-1:0]  FOCAL_RST      = 16'd8400;
    localparam logic [COLOUR_W-1:0] COLOUR_RST     = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_COL = 3'd0,
        CFG_CENTER_ROW = 3'd1,
        CFG_FOCAL      = 3'd2,
        CFG_RED        = 3'd3,
        CFG_GREEN      = 3'd4,
        CFG_BLUE       = 3'd5
    } t_cfg_idx;

    // one axis in flight through the divider
    typedef struct packed {
        logic               neg;
        logic               ovf;
        logic [FOCAL_W-1:0] rem;
        logic [QUO_W-1:0]   work;   // dividend bits out at the top, quotient bits in below
    } t_div_axis;

    typedef struct packed {
        t_div_axis          x;
        t_div_axis          y;
        logic [DEPTH_W-1:0] depth;
    } t_div_item;

    // restoring division, BITS_PER_STAGE quotient bits
    function automatic t_div_axis div_step(input t_div_axis a, input logic [FOCAL_W-1:0] divisor);
        t_div_axis        r;
        logic [FOCAL_W:0] trial;
        r = a;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            trial  = {r.rem, r.work[QUO_W-1]};
            r.work = {r.work[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                r.rem     = FOCAL_W'(trial - {1'b0, divisor});
                r.work[0] = 1'b1;
            end else begin
                r.rem = trial[FOCAL_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic t_div_item div_item_step(input t_div_item it,
                                                input logic [FOCAL_W-1:0] divisor);
        t_div_item r;
        r       = it;
        r.x     = div_step(it.x, divisor);
        r.y     = div_step(it.y, divisor);
        return r;
    endfunction

    // sign and saturation of a finished quotient magnitude
    function automatic logic [POS_W-1:0] sat_axis(input t_div_axis a);
        logic [POS_W-1:0] r;
        if (a.ovf || a.work[QUO_W-1]) begin
            r = a.neg ? POS_MIN : POS_MAX;
        end else begin
            r = a.neg ? POS_W'(~a.work + 1'b1) : POS_W'(a.work);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/dpb_pixel_if.sv
interface dpb_pixel_if import dpb_pkg::*; #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [DEPTH_W-1:0]    depth_mm;

    modport source (output valid, output pixel_col, output pixel_row, output depth_mm,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input depth_mm,
                    output ready);
endinterface

// File: hw/rtl/dpb_point_if.sv
interface dpb_point_if import dpb_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       point_valid;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic [DEPTH_W-1:0]         pos_z;
    logic [COLOUR_W-1:0]        point_red;
    logic [COLOUR_W-1:0]        point_green;
    logic [COLOUR_W-1:0]        point_blue;

    modport source (output valid, output point_valid, output pos_x, output pos_y,
                    output pos_z, output point_red, output point_green, output point_blue,
                    input ready);
    modport sink   (input valid, input point_valid, input pos_x, input pos_y,
                    input pos_z, input point_red, input point_green, input point_blue,
                    output ready);
endinterface

// File: hw/rtl/depth_pixel_backprojection.sv
// pinhole back-projection of depth pixels into coloured 3D points
// i_pix: one depth pixel per transaction (column, row, depth in mm, zero = no measurement)
// o_pt : one point per transaction, x and y in 1/16 mm (saturated), z in mm, fixed colour;
//        a zero depth gives an all-zero point with point_valid low
// i_cfg_*: plain register writes (principal point, focal length, colour), only while idle
// throughput: one transaction per cycle sustained while o_pt.ready stays high, through
//   the 12-stage pipeline (offset, multiply, divider set-up,
//   8 divider stages of 4 quotient bits each, saturation and output register)
// reset (synchronous, active low): pipeline emptied, registers back to their defaults
// stall: a stage holds while the one after it is full and stuck; empty stages still
//   fill, so i_pix.ready only falls once every stage holds a transaction
module depth_pixel_backprojection import dpb_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    dpb_pixel_if.sink            i_pix,
    dpb_point_if.source          o_pt
);

    // |16*coord - centre| magnitude, product and scaled dividend widths
    localparam int DMAG_W = (COORD_BITS + 4 > CFG_W) ? COORD_BITS + 4 : CFG_W;
    localparam int PROD_W = DMAG_W + DEPTH_W;
    localparam int NUM_W  = PROD_W + 4;
    localparam int HI_W   = NUM_W - QUO_W;
    localparam int CMP_W  = (HI_W > FOCAL_W) ? HI_W : FOCAL_W;
    // offset, multiply, divider set-up, divider stages, output
    localparam int NSTG   = 3 + DIV_STAGES + 1;
    localparam int S_DIV0 = 3;

    // configuration registers
    logic [CFG_W-1:0]    r_center_col;
    logic [CFG_W-1:0]    r_center_row;
    logic [FOCAL_W-1:0]  r_focal;
    logic [COLOUR_W-1:0] r_red;
    logic [COLOUR_W-1:0] r_green;
    logic [COLOUR_W-1:0] r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col <= CENTER_COL_RST;
            r_center_row <= CENTER_ROW_RST;
            r_focal      <= FOCAL_RST;
            r_red        <= COLOUR_RST;
            r_green      <= COLOUR_RST;
            r_blue       <= COLOUR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_COL: r_center_col <= i_cfg_data;
                CFG_CENTER_ROW: r_center_row <= i_cfg_data;
                CFG_FOCAL:      r_focal      <= i_cfg_data[FOCAL_W-1:0];
                CFG_RED:        r_red        <= i_cfg_data[COLOUR_W-1:0];
                CFG_GREEN:      r_green      <= i_cfg_data[COLOUR_W-1:0];
                CFG_BLUE:       r_blue       <= i_cfg_data[COLOUR_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // a zero focal length divides as one
    logic [FOCAL_W-1:0] focal_eff;
    assign focal_eff = (r_focal == '0) ? FOCAL_W'(1) : r_focal;

    // pipeline flow control: a stage loads when empty or when its content moves on
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] take;

    assign take[NSTG-1] = !r_vld[NSTG-1] || o_pt.ready;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_take
        assign take[k] = !r_vld[k] || take[k+1];
    end

    assign i_pix.ready = take[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (take[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: offset from the principal point, split into sign and magnitude
    logic signed [DMAG_W:0] diff_x;
    logic signed [DMAG_W:0] diff_y;
    logic                   n_s0_neg_x;
    logic                   n_s0_neg_y;
    logic [DMAG_W-1:0]      n_s0_mag_x;
    logic [DMAG_W-1:0]      n_s0_mag_y;

    assign diff_x = $signed((DMAG_W+1)'({i_pix.pixel_col, 4'b0000}))
                  - $signed((DMAG_W+1)'(r_center_col));
    assign diff_y = $signed((DMAG_W+1)'({i_pix.pixel_row, 4'b0000}))
                  - $signed((DMAG_W+1)'(r_center_row));
    assign n_s0_neg_x = diff_x[DMAG_W];
    assign n_s0_neg_y = diff_y[DMAG_W];
    assign n_s0_mag_x = n_s0_neg_x ? DMAG_W'(-diff_x) : DMAG_W'(diff_x);
    assign n_s0_mag_y = n_s0_neg_y ? DMAG_W'(-diff_y) : DMAG_W'(diff_y);

    logic               r_s0_neg_x;
    logic               r_s0_neg_y;
    logic [DMAG_W-1:0]  r_s0_mag_x;
    logic [DMAG_W-1:0]  r_s0_mag_y;
    logic [DEPTH_W-1:0] r_s0_depth;

    always_ff @(posedge i_clk) begin
        if (take[0]) begin
            r_s0_neg_x <= n_s0_neg_x;
            r_s0_neg_y <= n_s0_neg_y;
            r_s0_mag_x <= n_s0_mag_x;
            r_s0_mag_y <= n_s0_mag_y;
            r_s0_depth <= i_pix.depth_mm;
        end
    end

    // stage 1: |offset| * depth, one multiplier per axis
    logic               r_s1_neg_x;
    logic               r_s1_neg_y;
    logic [PROD_W-1:0]  r_s1_prod_x;
    logic [PROD_W-1:0]  r_s1_prod_y;
    logic [DEPTH_W-1:0] r_s1_depth;

    always_ff @(posedge i_clk) begin
        if (take[1]) begin
            r_s1_neg_x  <= r_s0_neg_x;
            r_s1_neg_y  <= r_s0_neg_y;
            r_s1_prod_x <= PROD_W'(r_s0_mag_x) * PROD_W'(r_s0_depth);
            r_s1_prod_y <= PROD_W'(r_s0_mag_y) * PROD_W'(r_s0_depth);
            r_s1_depth  <= r_s0_depth;
        end
    end

    // stage 2: dividend = product * 16; quotient of 2^32 or more means overflow,
    // otherwise the top bits become the starting remainder
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [HI_W-1:0]  hi_x;
    logic [HI_W-1:0]  hi_y;
    t_div_item        n_s2;

    assign num_x = {r_s1_prod_x, 4'b0000};
    assign num_y = {r_s1_prod_y, 4'b0000};
    assign hi_x  = num_x[NUM_W-1:QUO_W];
    assign hi_y  = num_y[NUM_W-1:QUO_W];

    always_comb begin
        n_s2.x.neg  = r_s1_neg_x;
        n_s2.x.ovf  = CMP_W'(hi_x) >= CMP_W'(focal_eff);
        n_s2.x.rem  = n_s2.x.ovf ? '0 : FOCAL_W'(hi_x);
        n_s2.x.work = num_x[QUO_W-1:0];
        n_s2.y.neg  = r_s1_neg_y;
        n_s2.y.ovf  = CMP_W'(hi_y) >= CMP_W'(focal_eff);
        n_s2.y.rem  = n_s2.y.ovf ? '0 : FOCAL_W'(hi_y);
        n_s2.y.work = num_y[QUO_W-1:0];
        n_s2.depth  = r_s1_depth;
    end

    t_div_item r_s2;

    always_ff @(posedge i_clk) begin
        if (take[2]) begin
            r_s2 <= n_s2;
        end
    end

    // divider stages, 4 quotient bits each
    t_div_item r_div [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (take[S_DIV0]) begin
                    r_div[0] <= div_item_step(r_s2, focal_eff);
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (take[S_DIV0+k]) begin
                    r_div[k] <= div_item_step(r_div[k-1], focal_eff);
                end
            end
        end
    end

    // output stage: sign, saturation, zero-depth blanking, colour
    t_div_item           last_div;
    logic                n_out_pvalid;
    logic                r_out_pvalid;
    logic [POS_W-1:0]    r_out_x;
    logic [POS_W-1:0]    r_out_y;
    logic [DEPTH_W-1:0]  r_out_z;
    logic [COLOUR_W-1:0] r_out_red;
    logic [COLOUR_W-1:0] r_out_green;
    logic [COLOUR_W-1:0] r_out_blue;

    assign last_div     = r_div[DIV_STAGES-1];
    assign n_out_pvalid = last_div.depth != '0;

    always_ff @(posedge i_clk) begin
        if (take[NSTG-1]) begin
            r_out_pvalid <= n_out_pvalid;
            r_out_x      <= n_out_pvalid ? sat_axis(last_div.x) : '0;
            r_out_y      <= n_out_pvalid ? sat_axis(last_div.y) : '0;
            r_out_z      <= last_div.depth;
            r_out_red    <= n_out_pvalid ? r_red   : '0;
            r_out_green  <= n_out_pvalid ? r_green : '0;
            r_out_blue   <= n_out_pvalid ? r_blue  : '0;
        end
    end

    assign o_pt.valid       = r_vld[NSTG-1];
    assign o_pt.point_valid = r_out_pvalid;
    assign o_pt.pos_x       = $signed(r_out_x);
    assign o_pt.pos_y       = $signed(r_out_y);
    assign o_pt.pos_z       = r_out_z;
    assign o_pt.point_red   = r_out_red;
    assign o_pt.point_green = r_out_green;
    assign o_pt.point_blue  = r_out_blue;

`ifndef ASSERT_OFF
    // an accepted pixel always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted pixel not captured");

    // input may only be refused when every stage is full and the output is stalled
    a_ready_bubbles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (&r_vld) && !o_pt.ready)
        else $error("input refused with room in the pipeline");

    // long division keeps the remainder below the divisor
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-2] && !last_div.x.ovf |-> last_div.x.rem < focal_eff)
        else $error("x remainder out of range");

    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-2] && !last_div.y.ovf |-> last_div.y.rem < focal_eff)
        else $error("y remainder out of range");

    // an invalid point is blank in every field
    a_blank_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid && !o_pt.point_valid |-> o_pt.pos_x == 0 && o_pt.pos_y == 0
            && o_pt.pos_z == 0 && o_pt.point_red == 0 && o_pt.point_green == 0
            && o_pt.point_blue == 0)
        else $error("invalid point not blanked");
`endif

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpb_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    // input transaction to output valid, matching the pipeline depth of the block
    localparam int PIPE_LATENCY    = 12;
    localparam int SETTLE_CYCLES   = PIPE_LATENCY + 4;
    // longest stretch with no transaction anywhere before the run is called hung
    localparam int WATCHDOG_LIMIT  = 3000;
    // receiver hold-off long enough to fill every pipeline stage
    localparam int RX_BURST_CYCLES = 300;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 183;

    localparam longint POS_HI = 64'sd2147483647;
    localparam longint POS_LO = -64'sd2147483648;

    // register indexes the block does not decode, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    depth;
    } depth_pixel_t;

    typedef struct packed {
        logic                    point_valid;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [DEPTH_W-1:0]      pos_z;
        logic [COLOUR_W-1:0]     red;
        logic [COLOUR_W-1:0]     green;
        logic [COLOUR_W-1:0]     blue;
    } point_t;

    typedef struct packed {
        logic [CFG_W-1:0]    ctr_col;
        logic [CFG_W-1:0]    ctr_row;
        logic [FOCAL_W-1:0]  focal;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } camera_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    dpb_pixel_if #(.COORD_BITS(COORD_BITS)) pix_if ();
    dpb_point_if                            pt_if ();

    depth_pixel_backprojection #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if.sink),
        .o_pt       (pt_if.source)
    );

    // camera settings as the block should currently hold them
    camera_t      cam;
    // pixels waiting to be offered, and points the block still owes us
    depth_pixel_t pixels_to_send[$];
    point_t       points_due[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_burst_req;
    int fail_count;
    int quiet_cycles;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // one axis of the pinhole back-projection in 1/16 mm, truncated then saturated
    function automatic logic signed [POS_W-1:0] project_coord(
        input logic [COORD_BITS-1:0] coord,
        input logic [CFG_W-1:0]      centre,
        input logic [DEPTH_W-1:0]    depth,
        input logic [FOCAL_W-1:0]    focal
    );
        longint offset_q4;
        longint scaled;
        longint divisor;
        longint quot;
        offset_q4 = longint'(coord) * 16 - longint'(centre);
        scaled    = offset_q4 * longint'(depth) * 16;
        // a zero focal length behaves as one
        divisor   = (focal == '0) ? 64'sd1 : longint'(focal);
        // signed integer division already rounds toward zero
        quot      = scaled / divisor;
        if (quot > POS_HI) begin
            quot = POS_HI;
        end else if (quot < POS_LO) begin
            quot = POS_LO;
        end
        return POS_W'(quot);
    endfunction

    function automatic point_t backproject(input depth_pixel_t px);
        point_t pt;
        pt = '0;
        // zero depth means no measurement: everything stays zero
        if (px.depth != '0) begin
            pt.point_valid = 1'b1;
            pt.pos_x       = project_coord(px.col, cam.ctr_col, px.depth, cam.focal);
            pt.pos_y       = project_coord(px.row, cam.ctr_row, px.depth, cam.focal);
            pt.pos_z       = px.depth;
            pt.red         = cam.red;
            pt.green       = cam.green;
            pt.blue        = cam.blue;
        end
        return pt;
    endfunction

    function automatic depth_pixel_t random_pixel();
        depth_pixel_t px;
        px.col = COORD_BITS'($urandom);
        px.row = COORD_BITS'($urandom);
        case ($urandom_range(0, 9))
            0:       px.depth = '0;
            1, 2:    px.depth = DEPTH_W'($urandom_range(1, 255));
            3:       px.depth = '1;
            default: px.depth = DEPTH_W'($urandom);
        endcase
        return px;
    endfunction

    function automatic camera_t random_camera();
        camera_t c;
        c.ctr_col = CFG_W'($urandom);
        c.ctr_row = CFG_W'($urandom);
        c.focal   = FOCAL_W'($urandom_range(1, 65535));
        c.red     = COLOUR_W'($urandom);
        c.green   = COLOUR_W'($urandom);
        c.blue    = COLOUR_W'($urandom);
        return c;
    endfunction

    task automatic queue_pixel(input int col, input int row, input int depth);
        depth_pixel_t px;
        px.col   = COORD_BITS'(col);
        px.row   = COORD_BITS'(row);
        px.depth = DEPTH_W'(depth);
        pixels_to_send = {pixels_to_send, px};
    endtask

    // write every register, plus the two undecoded indexes with junk
    task automatic program_camera(input camera_t c);
        logic [CFG_IDX_W-1:0] reg_idx [8];
        logic [CFG_W-1:0]     reg_data [8];
        reg_idx  = '{CFG_CENTER_COL, CFG_CENTER_ROW, CFG_FOCAL, CFG_RED, CFG_GREEN,
                     CFG_BLUE, CFG_SPARE_6, CFG_SPARE_7};
        // colour writes carry junk in the upper byte, only the low byte counts
        reg_data = '{c.ctr_col, c.ctr_row, c.focal,
                     {COLOUR_W'($urandom), c.red},
                     {COLOUR_W'($urandom), c.green},
                     {COLOUR_W'($urandom), c.blue},
                     CFG_W'($urandom), CFG_W'($urandom)};
        for (int i = 0; i < 8; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_idx[i];
            i_cfg_data <= reg_data[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cam = c;
    endtask

    // sender holds back until every owed point is in, then the pipe settles
    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || pix_if.valid || points_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // pixel driver: a new transaction is loaded once the current one is taken
    always @(posedge i_clk) begin
        depth_pixel_t sent;
        depth_pixel_t nxt;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                sent.col   = pix_if.pixel_col;
                sent.row   = pix_if.pixel_row;
                sent.depth = pix_if.depth_mm;
                points_due = {points_due, backproject(sent)};
            end
            if (!pix_if.valid || pix_if.ready) begin
                if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt              = pixels_to_send.pop_front();
                    pix_if.valid     <= 1'b1;
                    pix_if.pixel_col <= nxt.col;
                    pix_if.pixel_row <= nxt.row;
                    pix_if.depth_mm  <= nxt.depth;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // point monitor: checks each transaction against the oldest owed point and
    // drives ready, including the long hold-off bursts
    always @(posedge i_clk) begin
        point_t  got;
        point_t  want;
        static int rx_burst_seen = 0;
        static int rx_burst_left = 0;
        if (!i_rst_n) begin
            pt_if.ready <= 1'b0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                got.point_valid = pt_if.point_valid;
                got.pos_x       = pt_if.pos_x;
                got.pos_y       = pt_if.pos_y;
                got.pos_z       = pt_if.pos_z;
                got.red         = pt_if.point_red;
                got.green       = pt_if.point_green;
                got.blue        = pt_if.point_blue;
                if (points_due.size() == 0) begin
                    $error("point transaction with no pixel outstanding");
                    fail_count++;
                end else begin
                    want = points_due.pop_front();
                    if (got.point_valid !== want.point_valid) begin
                        $error("point_valid: expected %0d, got %0d",
                               want.point_valid, got.point_valid);
                        fail_count++;
                    end
                    if (got.pos_x !== want.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                        fail_count++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                        fail_count++;
                    end
                    if (got.pos_z !== want.pos_z) begin
                        $error("pos_z: expected %0d, got %0d", want.pos_z, got.pos_z);
                        fail_count++;
                    end
                    if (got.red !== want.red) begin
                        $error("point_red: expected %0d, got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("point_green: expected %0d, got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("point_blue: expected %0d, got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
            if (rx_burst_req != rx_burst_seen) begin
                rx_burst_seen = rx_burst_req;
                rx_burst_left = RX_BURST_CYCLES;
            end
            if (rx_burst_left > 0) begin
                rx_burst_left--;
                pt_if.ready <= 1'b0;
            end else begin
                pt_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog: any transaction or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (pix_if.valid && pix_if.ready)
                || (pt_if.valid && pt_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        camera_t setup;
        // everything the block sees is known from time zero
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        pix_if.valid     = 1'b0;
        pix_if.pixel_col = '0;
        pix_if.pixel_row = '0;
        pix_if.depth_mm  = '0;
        pt_if.ready      = 1'b0;
        tx_idle_pct      = 8;
        rx_idle_pct      = 60;
        rx_burst_req     = 0;
        fail_count       = 0;
        quiet_cycles     = 0;
        cam.ctr_col      = CENTER_COL_RST;
        cam.ctr_row      = CENTER_ROW_RST;
        cam.focal        = FOCAL_RST;
        cam.red          = COLOUR_RST;
        cam.green        = COLOUR_RST;
        cam.blue         = COLOUR_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, field extremes and zero depth
        queue_pixel(0, 0, 0);
        queue_pixel(4095, 4095, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(4095, 4095, 1);
        queue_pixel(0, 0, 65535);
        queue_pixel(4095, 4095, 65535);
        queue_pixel(4095, 0, 65535);
        queue_pixel(0, 4095, 65535);
        queue_pixel(320, 240, 1000);
        queue_pixel(2730, 1365, 43690);
        wait_idle();

        // directed: unit focal length drives x to the positive limit, y to the negative
        setup = '{ctr_col: 16'd0, ctr_row: 16'hFFFF, focal: 16'd1,
                  red: 8'hFF, green: 8'hAA, blue: 8'h55};
        program_camera(setup);
        queue_pixel(4095, 0, 65535);
        queue_pixel(0, 4095, 65535);
        queue_pixel(4095, 4095, 0);
        queue_pixel(1, 4095, 1);
        queue_pixel(2048, 2048, 32768);
        wait_idle();

        // directed: zero focal length acts as one, opposite saturation corners
        setup = '{ctr_col: 16'hFFFF, ctr_row: 16'd0, focal: 16'd0,
                  red: 8'h00, green: 8'hFF, blue: 8'h00};
        program_camera(setup);
        queue_pixel(0, 0, 65535);
        queue_pixel(4095, 4095, 65535);
        queue_pixel(4095, 4095, 1);
        queue_pixel(0, 1, 3);
        wait_idle();

        // directed: widest focal length, results shrink toward zero
        setup = '{ctr_col: 16'h8000, ctr_row: 16'd16, focal: 16'hFFFF,
                  red: 8'h5A, green: 8'hA5, blue: 8'hFF};
        program_camera(setup);
        queue_pixel(4095, 4095, 65535);
        queue_pixel(0, 0, 65535);
        queue_pixel(1, 1, 7);
        wait_idle();

        // random phases: sender dense / receiver often stalled, then swapped, then flat out
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 3)
                0: begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 60;
                end
                1: begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 8;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            setup = random_camera();
            case (phase)
                0: begin
                    setup.ctr_col = CENTER_COL_RST;
                    setup.ctr_row = CENTER_ROW_RST;
                    setup.focal   = FOCAL_RST;
                end
                2: begin
                    setup.ctr_col = '1;
                    setup.ctr_row = '0;
                    setup.focal   = '1;
                    setup.red     = '0;
                    setup.green   = '0;
                    setup.blue    = '0;
                end
                3: setup.focal = FOCAL_W'($urandom_range(1, 64));
                5: begin
                    setup.ctr_col = '0;
                    setup.ctr_row = '0;
                    setup.focal   = FOCAL_W'(1);
                    setup.red     = '1;
                    setup.green   = '1;
                    setup.blue    = '1;
                end
                8: setup.focal = FOCAL_W'($urandom_range(1, 1024));
                default: ;
            endcase
            program_camera(setup);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pixels_to_send = {pixels_to_send, random_pixel()};
            end
            // long receiver hold-off while pixels keep coming: pipeline fills, input stalls
            if (phase == 1 || phase == 7) begin
                rx_burst_req++;
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
